// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top level of the replacement policy block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, switched off while reset is high.
`define SRSBP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property at every rising edge, reset included.
`define SRSBP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/srsbp_pkg.sv =====
// Shared types, codes and constants of the RRIP replacement policy block.
`default_nettype none

package srsbp_pkg;

  // Parameter defaults
  localparam int DEF_NUM_SETS = 2048;
  localparam int DEF_NUM_WAYS = 16;

  // Field widths fixed by the interface
  localparam int SET_IN_W  = 11;
  localparam int WAY_IN_W  = 4;
  localparam int BLK_W     = 8;
  localparam int PC_W      = 48;
  localparam int THRESH_W  = 4;
  localparam int REPEAT_W  = 4;
  localparam int SET_IDX_W = 16;  // holds any set index up to 65535
  localparam int SIG_W     = 4;
  localparam int SIG_COUNT = 16;

  // Reuse table: 2048 slots, but the slot is a one-to-one spread of the
  // 4-bit signature, so only 16 slots are ever touched; store by signature.
  localparam int REUSE_ENTRIES = 2048;

  // Queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);

  localparam logic [1:0] RRPV_HIT  = 2'd0;
  localparam logic [1:0] RRPV_LONG = 2'd2;
  localparam logic [1:0] RRPV_MAX  = 2'd3;

  localparam logic [1:0] REUSE_RESET = 2'd1;
  localparam logic [1:0] REUSE_MAX   = 2'd3;
  localparam logic [1:0] REUSE_HOT   = 2'd2;

  localparam logic [REPEAT_W-1:0] REPEAT_MAX   = 4'd15;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 4'd6;

  // Operation codes of a classified item
  localparam logic [1:0] OP_VICTIM = 2'd0;
  localparam logic [1:0] OP_HIT    = 2'd1;
  localparam logic [1:0] OP_FILL   = 2'd2;

  typedef struct packed {
    logic [1:0]           op;
    logic [SET_IDX_W-1:0] set;
    logic [WAY_IN_W-1:0]  way;
    logic                 way_ok;
    logic [BLK_W-1:0]     blk;
    logic [SIG_W-1:0]     sig;
  } item_t;

endpackage

`default_nettype wire

// ===== rtl/core/srsbp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module srsbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                      wr_data,
  input  wire logic                                  rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/srsbp_front.sv =====
// Front end: accepts items, folds the set index into range and classifies them.
`default_nettype none

module srsbp_front #(
  parameter int NUM_SETS = srsbp_pkg::DEF_NUM_SETS,
  parameter int NUM_WAYS = srsbp_pkg::DEF_NUM_WAYS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            en,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_func,
  input  wire logic                            in_hit,
  input  wire logic [srsbp_pkg::SET_IN_W-1:0]  in_set,
  input  wire logic [srsbp_pkg::WAY_IN_W-1:0]  in_way,
  input  wire logic [srsbp_pkg::BLK_W-1:0]     in_blk,
  input  wire logic [srsbp_pkg::PC_W-1:0]      in_pc,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output srsbp_pkg::item_t                     out_item
);

  // set % NUM_SETS by reciprocal: q is the quotient or one below it
  localparam int     RECIP_SHIFT = 22;
  localparam longint RECIP       = (longint'(1) << RECIP_SHIFT) / NUM_SETS;

  logic [33:0] recip_prod;
  logic        a_valid;
  logic [srsbp_pkg::SET_IN_W-1:0] a_x;
  logic [srsbp_pkg::SET_IN_W-1:0] a_q;
  logic [1:0]                     a_op;
  logic [srsbp_pkg::WAY_IN_W-1:0] a_way;
  logic                           a_way_ok;
  logic [srsbp_pkg::BLK_W-1:0]    a_blk;
  logic [srsbp_pkg::SIG_W-1:0]    a_sig;
  logic [27:0]                    qn_prod;
  logic [17:0]                    rem_raw;
  logic [17:0]                    rem;
  logic                           take;
  logic [1:0]                     op_in;

  assign recip_prod = 34'(in_set) * 34'(RECIP);
  assign in_ready   = en && (!a_valid || out_ready);
  assign take       = in_valid && in_ready;

  always_comb begin
    if (!in_func) begin
      op_in = srsbp_pkg::OP_VICTIM;
    end else if (in_hit) begin
      op_in = srsbp_pkg::OP_HIT;
    end else begin
      op_in = srsbp_pkg::OP_FILL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (take) begin
      a_valid <= 1'b1;
    end else if (out_ready) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_x      <= in_set;
      a_q      <= recip_prod[32:22];
      a_op     <= op_in;
      a_way    <= in_way;
      a_way_ok <= (6'(in_way) < 6'(NUM_WAYS));
      a_blk    <= in_blk;
      a_sig    <= in_pc[5:2] ^ in_pc[14:11];
    end
  end

  // remainder lands in [0, 2*NUM_SETS): one compare and subtract fixes it
  assign qn_prod = 28'(a_q) * 28'(NUM_SETS);
  assign rem_raw = 18'(a_x) - qn_prod[17:0];
  assign rem     = (rem_raw >= 18'(NUM_SETS)) ? (rem_raw - 18'(NUM_SETS)) : rem_raw;

  assign out_valid       = a_valid;
  assign out_item.op     = a_op;
  assign out_item.set    = rem[srsbp_pkg::SET_IDX_W-1:0];
  assign out_item.way    = a_way;
  assign out_item.way_ok = a_way_ok;
  assign out_item.blk    = a_blk;
  assign out_item.sig    = a_sig;

endmodule

`default_nettype wire

// ===== rtl/core/srsbp_queue.sv =====
// Short queue of classified items between the front end and the back end.
`default_nettype none

module srsbp_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  srsbp_pkg::item_t      in_item,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output srsbp_pkg::item_t      out_item
);

  srsbp_pkg::item_t entries [srsbp_pkg::QDEPTH];

  logic [srsbp_pkg::QPTR_W-1:0] wr_ptr;
  logic [srsbp_pkg::QPTR_W-1:0] rd_ptr;
  logic [srsbp_pkg::QPTR_W:0]   count;
  logic                         push;
  logic                         pop;

  assign in_ready  = (count != (srsbp_pkg::QPTR_W + 1)'(srsbp_pkg::QDEPTH));
  assign out_valid = (count != '0);
  assign out_item  = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == srsbp_pkg::QPTR_W'(srsbp_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == srsbp_pkg::QPTR_W'(srsbp_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/srsbp_back.sv =====
// Back end: reads a set's row, applies victim, hit or fill, writes it back.
`default_nettype none

module srsbp_back #(
  parameter int NUM_SETS = srsbp_pkg::DEF_NUM_SETS,
  parameter int NUM_WAYS = srsbp_pkg::DEF_NUM_WAYS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [srsbp_pkg::THRESH_W-1:0] thresh,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  srsbp_pkg::item_t                    in_item,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [srsbp_pkg::WAY_IN_W-1:0]      out_victim,
  output logic                                out_bypassed,
  output logic                                clearing
);

  localparam int SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W     = $clog2(NUM_WAYS);
  localparam int RV_W      = 2 * NUM_WAYS;
  localparam int BLK_LO    = RV_W;
  localparam int STRIDE_LO = RV_W + srsbp_pkg::BLK_W;
  localparam int REPS_LO   = STRIDE_LO + srsbp_pkg::BLK_W;
  localparam int ROW_W     = REPS_LO + srsbp_pkg::REPEAT_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic             state;
  srsbp_pkg::item_t cur;
  logic [SET_W-1:0] clear_cnt;
  logic [1:0]       reuse [srsbp_pkg::SIG_COUNT];

  logic             pop;
  logic             exec_fire;
  logic             wr_en;
  logic [SET_W-1:0] wr_addr;
  logic [ROW_W-1:0] wr_data;
  logic [ROW_W-1:0] rd_row;
  logic [ROW_W-1:0] new_row;
  logic [ROW_W-1:0] clear_row;

  logic [1:0] rv     [NUM_WAYS];
  logic [1:0] aged   [NUM_WAYS];
  logic [1:0] rv_new [NUM_WAYS];
  logic       any3;
  logic       any2;
  logic       any1;
  logic [1:0] add;
  logic [WAY_W-1:0] vic;
  logic [WAY_W-1:0] widx;

  logic [srsbp_pkg::BLK_W-1:0]    old_blk;
  logic [srsbp_pkg::BLK_W-1:0]    old_stride;
  logic [srsbp_pkg::REPEAT_W-1:0] old_reps;
  logic [srsbp_pkg::BLK_W-1:0]    delta;
  logic [srsbp_pkg::BLK_W-1:0]    new_blk;
  logic [srsbp_pkg::BLK_W-1:0]    new_stride;
  logic [srsbp_pkg::REPEAT_W-1:0] new_reps;
  logic                           stream;
  logic [1:0]                     reuse_val;
  logic [1:0]                     reuse_new;
  logic                           reuse_upd;
  logic [srsbp_pkg::WAY_IN_W-1:0] res_victim;
  logic                           res_bypassed;

  assign in_ready  = (state == ST_IDLE) && !clearing;
  assign pop       = in_valid && in_ready;
  assign exec_fire = (state == ST_EXEC) && (!out_valid || out_ready);

  srsbp_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (pop),
    .rd_addr (in_item.set[SET_W-1:0]),
    .rd_data (rd_row)
  );

  assign clear_row = {{(ROW_W - RV_W){1'b0}}, {NUM_WAYS{srsbp_pkg::RRPV_MAX}}};
  assign wr_en     = clearing || exec_fire;
  assign wr_addr   = clearing ? clear_cnt : cur.set[SET_W-1:0];
  assign wr_data   = clearing ? clear_row : new_row;

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      rv[w] = rd_row[2*w +: 2];
    end
    any3 = 1'b0;
    any2 = 1'b0;
    any1 = 1'b0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      any3 = any3 | (rv[w] == 2'd3);
      any2 = any2 | (rv[w] == 2'd2);
      any1 = any1 | (rv[w] == 2'd1);
    end
    // age every way by the gap between the largest value and the maximum
    if (any3) begin
      add = 2'd0;
    end else if (any2) begin
      add = 2'd1;
    end else if (any1) begin
      add = 2'd2;
    end else begin
      add = 2'd3;
    end
    for (int w = 0; w < NUM_WAYS; w++) begin
      aged[w] = rv[w] + add;
    end
    vic = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (aged[w] == srsbp_pkg::RRPV_MAX) begin
        vic = WAY_W'(w);
      end
    end
  end

  always_comb begin
    old_blk    = rd_row[BLK_LO +: srsbp_pkg::BLK_W];
    old_stride = rd_row[STRIDE_LO +: srsbp_pkg::BLK_W];
    old_reps   = rd_row[REPS_LO +: srsbp_pkg::REPEAT_W];
    delta      = cur.blk - old_blk;
    new_stride = old_stride;
    new_reps   = old_reps;
    if (delta != '0) begin
      if (old_stride == delta) begin
        if (old_reps != srsbp_pkg::REPEAT_MAX) begin
          new_reps = old_reps + 1'b1;
        end
      end else begin
        new_stride = delta;
        new_reps   = srsbp_pkg::REPEAT_W'(1);
      end
    end
    stream = (delta != '0) && (new_reps >= thresh);
  end

  always_comb begin
    widx         = WAY_W'(cur.way);
    reuse_val    = reuse[cur.sig];
    reuse_new    = reuse_val;
    reuse_upd    = 1'b0;
    res_victim   = '0;
    res_bypassed = 1'b0;
    new_blk      = old_blk;
    for (int w = 0; w < NUM_WAYS; w++) begin
      rv_new[w] = rv[w];
    end
    case (cur.op)
      srsbp_pkg::OP_VICTIM: begin
        for (int w = 0; w < NUM_WAYS; w++) begin
          rv_new[w] = aged[w];
        end
        res_victim = srsbp_pkg::WAY_IN_W'(vic);
      end
      srsbp_pkg::OP_HIT: begin
        if (cur.way_ok) begin
          rv_new[widx] = srsbp_pkg::RRPV_HIT;
        end
        if (reuse_val != srsbp_pkg::REUSE_MAX) begin
          reuse_new = reuse_val + 1'b1;
          reuse_upd = 1'b1;
        end
      end
      srsbp_pkg::OP_FILL: begin
        new_blk = cur.blk;
        if (stream) begin
          // streaming fill: insert it at the maximum value, among the first to be evicted
          if (cur.way_ok) begin
            rv_new[widx] = srsbp_pkg::RRPV_MAX;
          end
          res_bypassed = 1'b1;
        end else if (reuse_val >= srsbp_pkg::REUSE_HOT) begin
          if (cur.way_ok) begin
            rv_new[widx] = srsbp_pkg::RRPV_LONG;
          end
        end else begin
          if (cur.way_ok) begin
            rv_new[widx] = srsbp_pkg::RRPV_MAX;
          end
          if (reuse_val != 2'd0) begin
            reuse_new = reuse_val - 1'b1;
            reuse_upd = 1'b1;
          end
        end
      end
      default: begin
        reuse_upd = 1'b0;
      end
    endcase
  end

  always_comb begin
    new_row = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      new_row[2*w +: 2] = rv_new[w];
    end
    if (cur.op == srsbp_pkg::OP_FILL) begin
      new_row[BLK_LO +: srsbp_pkg::BLK_W]       = new_blk;
      new_row[STRIDE_LO +: srsbp_pkg::BLK_W]    = new_stride;
      new_row[REPS_LO +: srsbp_pkg::REPEAT_W]   = new_reps;
    end else begin
      new_row[BLK_LO +: srsbp_pkg::BLK_W]       = old_blk;
      new_row[STRIDE_LO +: srsbp_pkg::BLK_W]    = old_stride;
      new_row[REPS_LO +: srsbp_pkg::REPEAT_W]   = old_reps;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      clearing  <= 1'b1;
      clear_cnt <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < srsbp_pkg::SIG_COUNT; i++) begin
        reuse[i] <= srsbp_pkg::REUSE_RESET;
      end
    end else begin
      if (clearing) begin
        if (clear_cnt == SET_W'(NUM_SETS - 1)) begin
          clearing <= 1'b0;
        end else begin
          clear_cnt <= clear_cnt + 1'b1;
        end
      end
      case (state)
        ST_IDLE: begin
          if (pop) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec_fire) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (exec_fire) begin
        out_valid <= 1'b1;
        if (reuse_upd) begin
          reuse[cur.sig] <= reuse_new;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= in_item;
    end
    if (exec_fire) begin
      out_victim   <= res_victim;
      out_bypassed <= res_bypassed;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ship_rrip_stream_bypass_policy.sv =====
// Top level of the RRIP replacement policy with signature insertion and stream bypass.
// Path: an accepted item is registered in the front end, held in the queue, then read with
// its set's row in the back end, whose result is registered; the back end takes no new item
// until it has written back the last one's row. Reset: control clears at once; a sweep then
// rewrites every row while s_tready stays low (configuration writes are still taken).
`default_nettype none
`include "assert_macros.svh"

module ship_rrip_stream_bypass_policy #(
  parameter int NUM_SETS = srsbp_pkg::DEF_NUM_SETS,
  parameter int NUM_WAYS = srsbp_pkg::DEF_NUM_WAYS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [71:0] s_tdata,   // set_index, way_index, block_addr_low, pc, pad
  input  wire logic [1:0]  s_tuser,   // func, hit
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // victim_way, pad
  output logic [0:0]       m_tuser,   // bypassed
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data   // stream_threshold
);

  logic [srsbp_pkg::THRESH_W-1:0] thresh;
  logic                           clearing;
  logic                           f_valid;
  logic                           f_ready;
  srsbp_pkg::item_t               f_item;
  logic                           q_valid;
  logic                           q_ready;
  srsbp_pkg::item_t               q_item;
  logic [srsbp_pkg::WAY_IN_W-1:0] victim;
  logic                           bypassed;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= srsbp_pkg::THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thresh <= cfg_data;
    end
  end

  srsbp_front #(
    .NUM_SETS (NUM_SETS),
    .NUM_WAYS (NUM_WAYS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (!clearing),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_func   (s_tuser[0]),
    .in_hit    (s_tuser[1]),
    .in_set    (s_tdata[10:0]),
    .in_way    (s_tdata[14:11]),
    .in_blk    (s_tdata[22:15]),
    .in_pc     (s_tdata[70:23]),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_item  (f_item)
  );

  srsbp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  srsbp_back #(
    .NUM_SETS (NUM_SETS),
    .NUM_WAYS (NUM_WAYS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .thresh       (thresh),
    .in_valid     (q_valid),
    .in_ready     (q_ready),
    .in_item      (q_item),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_victim   (victim),
    .out_bypassed (bypassed),
    .clearing     (clearing)
  );

  assign m_tdata    = {4'd0, victim};
  assign m_tuser[0] = bypassed;

  `SRSBP_ASSERT(a_no_take_while_clearing, clk, rst, !(s_tready && clearing), "item taken during row sweep")
  `SRSBP_ASSERT(a_bypass_no_victim, clk, rst, (m_tvalid && m_tuser[0]) |-> (m_tdata == 8'd0), "bypassed result carries a victim way")
  `SRSBP_ASSERT(a_no_result_after_sweep, clk, rst, $fell(clearing) |-> !m_tvalid, "result present before any item could enter")

endmodule

`default_nettype wire

// ===== sim/policy_tb_pkg.sv =====
// Field layouts and function codes shared by the replacement policy testbench files.
`default_nettype none

package policy_tb_pkg;

  typedef enum logic {
    FUNC_VICTIM = 1'b0,
    FUNC_UPDATE = 1'b1
  } func_e;

  // s_tdata layout, lowest bits last in the list
  typedef struct packed {
    logic                         pad;
    logic [srsbp_pkg::PC_W-1:0]     pc;
    logic [srsbp_pkg::BLK_W-1:0]    blk_low;
    logic [srsbp_pkg::WAY_IN_W-1:0] way_index;
    logic [srsbp_pkg::SET_IN_W-1:0] set_index;
  } access_data_t;

  // s_tuser layout: func in bit 0, hit in bit 1
  typedef struct packed {
    logic  hit;
    func_e func;
  } access_flags_t;

  typedef struct packed {
    logic [3:0] victim_way;
    logic       bypassed;
  } outcome_t;

endpackage

`default_nettype wire

// ===== sim/rrip_policy_checker.sv =====
// Checker for the RRIP replacement policy: tracks policy state and compares every result.
`default_nettype none

module rrip_policy_checker
  import srsbp_pkg::*;
  import policy_tb_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  input  wire logic          s_tready,
  input  wire access_data_t  s_tdata,
  input  wire access_flags_t s_tuser,
  input  wire logic          m_tvalid,
  input  wire logic          m_tready,
  input  wire logic [7:0]    m_tdata,
  input  wire logic [0:0]    m_tuser,
  input  wire logic          cfg_valid,
  input  wire logic          cfg_ready,
  input  wire logic [3:0]    cfg_data,
  output int                 errors,
  output int                 pending
);

  localparam int NSETS = DEF_NUM_SETS;
  localparam int NWAYS = DEF_NUM_WAYS;

  logic [1:0]          rrpv_mem   [NSETS][NWAYS];
  logic [1:0]          reuse_ctr  [REUSE_ENTRIES];
  logic [BLK_W-1:0]    last_blk   [NSETS];
  logic [BLK_W-1:0]    last_delta [NSETS];
  logic [REPEAT_W-1:0] repeat_cnt [NSETS];
  logic [THRESH_W-1:0] threshold;

  outcome_t results_due[$];
  int       fail_count = 0;

  function automatic void clear_policy();
    for (int s = 0; s < NSETS; s++) begin
      for (int w = 0; w < NWAYS; w++) rrpv_mem[s][w] = RRPV_MAX;
      last_blk[s]   = '0;
      last_delta[s] = '0;
      repeat_cnt[s] = '0;
    end
    for (int i = 0; i < REUSE_ENTRIES; i++) reuse_ctr[i] = REUSE_RESET;
    threshold = THRESH_RESET;
  endfunction

  // Apply one access to the tracked state and return the result it must produce.
  function automatic outcome_t apply_access(access_data_t d, func_e func, logic hit);
    outcome_t         r;
    logic [1:0]       top;
    logic [3:0]       sig;
    logic [10:0]      slot;
    logic [BLK_W-1:0] delta;
    logic             streaming;
    int               s;
    int               w;
    r   = '0;
    s   = int'(d.set_index) % NSETS;
    w   = int'(d.way_index);
    if (func == FUNC_VICTIM) begin
      top = '0;
      for (int i = 0; i < NWAYS; i++) if (rrpv_mem[s][i] > top) top = rrpv_mem[s][i];
      if (top < RRPV_MAX)
        for (int i = 0; i < NWAYS; i++) rrpv_mem[s][i] = rrpv_mem[s][i] + (RRPV_MAX - top);
      for (int i = NWAYS - 1; i >= 0; i--)
        if (rrpv_mem[s][i] == RRPV_MAX) r.victim_way = 4'(i);
      return r;
    end
    sig  = d.pc[5:2] ^ d.pc[14:11];
    slot = 11'(sig) ^ (11'(sig) << 5) ^ (11'(sig) << 9);
    if (hit) begin
      if (w < NWAYS) rrpv_mem[s][w] = RRPV_HIT;
      if (reuse_ctr[slot] < REUSE_MAX) reuse_ctr[slot]++;
      return r;
    end
    // Stride detector: a zero delta leaves stride and count alone
    delta       = d.blk_low - last_blk[s];
    last_blk[s] = d.blk_low;
    streaming   = 1'b0;
    if (delta != '0) begin
      if (last_delta[s] == delta) begin
        if (repeat_cnt[s] < REPEAT_MAX) repeat_cnt[s]++;
      end else begin
        last_delta[s] = delta;
        repeat_cnt[s] = 4'd1;
      end
      streaming = repeat_cnt[s] >= threshold;
    end
    if (streaming) begin
      if (w < NWAYS) rrpv_mem[s][w] = RRPV_MAX;
      r.bypassed = 1'b1;
    end else if (reuse_ctr[slot] >= REUSE_HOT) begin
      if (w < NWAYS) rrpv_mem[s][w] = RRPV_LONG;
    end else begin
      if (w < NWAYS) rrpv_mem[s][w] = RRPV_MAX;
      if (reuse_ctr[slot] > 0) reuse_ctr[slot]--;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      clear_policy();
      results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) threshold = cfg_data;
      if (m_tvalid && m_tready) begin
        if (results_due.size() == 0) begin
          $error("result with no expectation waiting: victim_way %0d bypassed %0d",
                 m_tdata[3:0], m_tuser[0]);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          if (m_tdata[3:0] !== want.victim_way) begin
            $error("victim_way: expected %0d, got %0d", want.victim_way, m_tdata[3:0]);
            fail_count++;
          end
          if (m_tuser[0] !== want.bypassed) begin
            $error("bypassed: expected %0d, got %0d", want.bypassed, m_tuser[0]);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready)
        results_due.push_back(apply_access(s_tdata, s_tuser.func, s_tuser.hit));
    end
    errors  <= fail_count;
    pending <= results_due.size();
  end

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Top of the replacement policy testbench: clock, reset, stimulus and verdict.
`default_nettype none

module testbench;
  import policy_tb_pkg::*;

  localparam int STALL_LIMIT  = 10000;
  localparam int SETTLE_GUARD = 12;
  localparam int PHASE_ITEMS  = 380;

  logic          clk;
  logic          rst       = 1'b1;
  logic          s_tvalid  = 1'b0;
  logic          s_tready;
  access_data_t  s_tdata   = '0;
  access_flags_t s_tuser   = '0;
  logic          m_tvalid;
  logic          m_tready  = 1'b0;
  logic [7:0]    m_tdata;
  logic [0:0]    m_tuser;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [3:0]    cfg_data  = '0;

  int            errors;
  int            pending;
  int            burst_left  = 0;
  int            rx_left     = 0;
  int            quiet_count = 0;
  logic [10:0]   hot_sets [8];

  ship_rrip_stream_bypass_policy u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  rrip_policy_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: alternate ready runs and stalls, now and then a long run with no stall
  always @(posedge clk) begin
    if (rx_left > 0) begin
      rx_left <= rx_left - 1;
    end else begin
      m_tready <= !m_tready;
      if (m_tready) rx_left <= $urandom_range(0, 12);
      else if ($urandom_range(0, 3) == 0) rx_left <= $urandom_range(20, 80);
      else rx_left <= $urandom_range(0, 8);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_count <= 0;
    end else if (quiet_count == STALL_LIMIT) begin
      $display("[ship_rrip_stream_bypass_policy] ERROR");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  // Hold the item until taken, then either keep the burst going or drop valid for a gap
  task automatic send_item(input func_e func, input logic [10:0] set_index,
                           input logic [3:0] way_index, input logic [7:0] blk_low,
                           input logic [47:0] pc, input logic hit);
    s_tvalid <= 1'b1;
    s_tdata  <= '{pad: 1'b0, pc: pc, blk_low: blk_low, way_index: way_index,
                  set_index: set_index};
    s_tuser  <= '{hit: hit, func: func};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_GUARD) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [3:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Runs of accesses to one set, mostly strided fills mixed with victim requests and hits
  task automatic run_traffic(input int n_items);
    int          sent;
    int          pick;
    logic [10:0] set_index;
    logic [7:0]  blk;
    logic [7:0]  stride;
    logic [47:0] pc;
    sent = 0;
    while (sent < n_items) begin
      set_index = ($urandom_range(0, 9) < 8) ? hot_sets[$urandom_range(0, 7)]
                                             : 11'($urandom);
      stride    = $urandom_range(0, 1) ? 8'($urandom_range(1, 4)) : 8'($urandom_range(1, 255));
      blk       = 8'($urandom);
      repeat ($urandom_range(1, 24)) begin
        pc   = {16'($urandom), 32'($urandom)};
        pick = $urandom_range(0, 19);
        if (pick < 5) begin
          send_item(FUNC_VICTIM, set_index, 4'($urandom), 8'($urandom), pc, 1'($urandom));
        end else if (pick < 8) begin
          send_item(FUNC_UPDATE, set_index, 4'($urandom), 8'($urandom), pc, 1'b1);
        end else begin
          // break the stride now and then, or refill the same block
          if (pick == 19) blk = 8'($urandom);
          else if (pick != 18) blk = blk + stride;
          send_item(FUNC_UPDATE, set_index, 4'($urandom), blk, pc, 1'b0);
        end
        sent++;
      end
    end
  endtask

  initial begin
    hot_sets[0] = 11'd0;
    hot_sets[1] = 11'd2047;
    for (int i = 2; i < 8; i++) hot_sets[i] = 11'($urandom);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed accesses under the reset threshold
    send_item(FUNC_VICTIM, 11'd0, 4'd0, 8'd0, 48'd0, 1'b0);
    send_item(FUNC_UPDATE, 11'd0, 4'd0, 8'd0, 48'd0, 1'b1);
    send_item(FUNC_VICTIM, 11'd0, 4'd15, 8'd255, 48'hFFFF_FFFF_FFFF, 1'b1);
    send_item(FUNC_UPDATE, 11'd0, 4'd15, 8'd0, 48'd0, 1'b0);
    send_item(FUNC_UPDATE, 11'd2047, 4'd15, 8'd255, 48'hFFFF_FFFF_FFFF, 1'b0);
    send_item(FUNC_UPDATE, 11'd2047, 4'd8, 8'd255, 48'hFFFF_FFFF_FFFF, 1'b1);
    for (int i = 1; i <= 7; i++)
      send_item(FUNC_UPDATE, 11'd5, 4'(i), 8'(i), 48'h0000_0000_4000, 1'b0);
    send_item(FUNC_UPDATE, 11'd5, 4'd9, 8'd7, 48'h0000_0000_4000, 1'b0);
    send_item(FUNC_VICTIM, 11'd5, 4'd0, 8'd0, 48'd0, 1'b0);
    send_item(FUNC_UPDATE, 11'd5, 4'd10, 8'd9, 48'h0000_0000_003C, 1'b0);
    send_item(FUNC_VICTIM, 11'd2047, 4'd0, 8'd0, 48'd0, 1'b0);
    send_item(FUNC_VICTIM, 11'd0, 4'd0, 8'd0, 48'd0, 1'b0);

    write_threshold(4'd1);
    run_traffic(PHASE_ITEMS);
    write_threshold(4'd15);
    run_traffic(PHASE_ITEMS);
    write_threshold(4'd0);
    run_traffic(PHASE_ITEMS);
    write_threshold(4'd9);
    run_traffic(PHASE_ITEMS);
    write_threshold(4'($urandom_range(2, 14)));
    run_traffic(PHASE_ITEMS);

    drain();
    if (errors == 0) begin
      $display("[ship_rrip_stream_bypass_policy] OK");
    end else begin
      $display("[ship_rrip_stream_bypass_policy] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl/core
rtl/core/srsbp_pkg.sv
rtl/core/srsbp_ram.sv
rtl/core/srsbp_front.sv
rtl/core/srsbp_queue.sv
rtl/core/srsbp_back.sv
rtl/core/ship_rrip_stream_bypass_policy.sv
sim/policy_tb_pkg.sv
sim/rrip_policy_checker.sv
sim/testbench.sv
